[hdl/bcd_segment_brightness_monitor_top_macros.svh]
// Assertion macros used by the checker file of the brightness monitor.
`ifndef BCD_SEGMENT_BRIGHTNESS_MONITOR_TOP_MACROS_SVH
`define BCD_SEGMENT_BRIGHTNESS_MONITOR_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BSBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle, outside reset.
`define BSBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define BSBM_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bsbm_pkg.sv]
// Types, constants and the segment decode table of the brightness monitor.
package bsbm_pkg;

  localparam int            CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_STEPS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN  = 2'd3;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FRAME  = 1'b1;

  localparam logic [16:0] TICK_MAX = 17'h1FFFF;

  typedef struct packed {
    logic        latch_mode;
    logic [7:0]  pin_connected_mask;
    logic [15:0] skip_steps;
    logic [15:0] steps_per_frame;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [3:0] bcd_pins;
    logic [3:0] digit_pins;
  } in_item_t;

  typedef struct packed {
    logic [1:0] digit_index;
    logic [7:0] bright_a;
    logic [7:0] bright_b;
    logic [7:0] bright_c;
    logic [7:0] bright_d;
    logic [7:0] bright_e;
    logic [7:0] bright_f;
    logic [7:0] bright_g;
    logic [7:0] bright_point;
    logic       row_changed;
    logic       last_row;
  } out_row_t;

  // Segment pattern, bit 0 = a ... bit 6 = g; codes above nine are blank.
  function automatic logic [6:0] seg_decode(logic [3:0] code);
    logic [6:0] pat;
    case (code)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

[hdl/bcd_segment_brightness_monitor_top.sv]
// Top level of the BCD seven-segment decoder brightness monitor.
//
// Input side is a queue: drive in_item and in_push; the item is taken on a
// clock edge where in_full is low. Results come out of a queue: while
// out_empty is low, out_row holds the oldest row; out_pop takes it.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata;
// the user writes them only while the block is idle; the block does not enforce it.
// Tick items are taken one per cycle while in_full is low; the front end
// decimates and decodes them and hands samples to the back end through a
// two-entry queue, and the back end updates its lit counters per sample.
// A frame-end item produces DIGITS rows. The back end runs each of the
// DIGITS*8 segments through a multiply, add, saturation check and an
// 8-step restoring divider, and emits a row after each digit.
// Ticks behind a frame end wait in the command queue and then stall input.
// If out_pop stays low, two rows wait in the result queue and the back
// end holds; the input side keeps accepting until the command queue fills.
// Synchronous reset clears counters, latches, the level valid bits and
// both queues at once; no clearing pass follows.
module bcd_segment_brightness_monitor_top #(
  parameter int DIGITS     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  input  bsbm_pkg::in_item_t                    in_item,
  output logic                                  in_full,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output bsbm_pkg::out_row_t                    out_row,
  input  logic                                  cfg_we,
  input  logic [bsbm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                           cfg_wdata
);

  import bsbm_pkg::*;

  localparam int CMD_W = DIGITS * 7 + 1;
  localparam int ROW_W = $bits(out_row_t);

  cfg_t              cfg_r;
  logic              cmd_push;
  logic [CMD_W-1:0]  cmd_din;
  logic              cmd_full;
  logic              cmd_pop;
  logic [CMD_W-1:0]  cmd_dout;
  logic              cmd_empty;
  logic              row_push;
  out_row_t          row_data;
  logic              row_full;
  logic [ROW_W-1:0]  row_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.latch_mode         <= 1'b0;
      cfg_r.pin_connected_mask <= 8'd0;
      cfg_r.skip_steps         <= 16'd0;
      cfg_r.steps_per_frame    <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LATCH_MODE: cfg_r.latch_mode         <= cfg_wdata[0];
        REG_PIN_MASK:   cfg_r.pin_connected_mask <= cfg_wdata[7:0];
        REG_SKIP_STEPS: cfg_r.skip_steps         <= cfg_wdata;
        REG_FRAME_LEN:  cfg_r.steps_per_frame    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bsbm_front #(.DIGITS(DIGITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_din),
    .cmd_full (cmd_full)
  );

  bsbm_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_din),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  bsbm_back #(.DIGITS(DIGITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_dout),
    .cmd_pop   (cmd_pop),
    .row_push  (row_push),
    .row_data  (row_data),
    .row_full  (row_full)
  );

  bsbm_fifo #(.WIDTH(ROW_W), .DEPTH(2)) u_row_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (row_push),
    .din   (row_data),
    .full  (row_full),
    .pop   (out_pop),
    .dout  (row_dout),
    .empty (out_empty)
  );

  assign out_row = out_row_t'(row_dout);

endmodule

[hdl/bsbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bsbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[hdl/bsbm_fifo.sv]
// Small register queue with push/full and pop/empty sides.
module bsbm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

[hdl/bsbm_front.sv]
// Front end: accepts items, decimates ticks, decodes pins and runs the digit latches.
module bsbm_front #(
  parameter int DIGITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsbm_pkg::cfg_t      cfg,
  input  logic                in_push,
  input  bsbm_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                cmd_push,
  output logic [DIGITS*7:0]   cmd_data,
  input  logic                cmd_full
);

  import bsbm_pkg::*;

  logic [16:0]             tick_r;
  logic [16:0]             tick_inc;
  logic [DIGITS-1:0][6:0]  latch_r;
  logic [DIGITS-1:0][6:0]  latch_nxt;
  logic [DIGITS-1:0][6:0]  cnt_pat;
  logic [3:0]              conn;
  logic [7:0]              high_ext;
  logic [7:0]              low_ext;
  logic [6:0]              pat;
  logic                    take;
  logic                    accept;
  logic                    is_frame;

  always_comb begin
    conn     = cfg.pin_connected_mask[7:4];
    high_ext = {4'b0, in_item.digit_pins & conn};
    low_ext  = {4'b0, ~in_item.digit_pins & conn};
    pat      = seg_decode(in_item.bcd_pins & cfg.pin_connected_mask[3:0]);
    tick_inc = (tick_r != TICK_MAX) ? tick_r + 1'b1 : tick_r;
    take     = (tick_inc >= ({1'b0, cfg.skip_steps} + 17'd2));
    for (int d = 0; d < DIGITS; d++) begin
      if (cfg.latch_mode) begin
        latch_nxt[d] = low_ext[d] ? pat : latch_r[d];
        cnt_pat[d]   = latch_nxt[d];
      end else begin
        latch_nxt[d] = latch_r[d];
        cnt_pat[d]   = high_ext[d] ? pat : 7'h00;
      end
    end
    is_frame = (in_item.action == ACT_FRAME);
    accept   = in_push && !cmd_full;
    cmd_push = accept && (is_frame || take);
    cmd_data = {(is_frame ? CMD_FRAME : CMD_SAMPLE), cnt_pat};
  end

  assign in_full = cmd_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= TICK_MAX;
      latch_r <= '0;
    end else if (accept) begin
      if (is_frame) begin
        // next frame samples on its first tick
        tick_r <= TICK_MAX;
      end else if (take) begin
        tick_r  <= '0;
        latch_r <= latch_nxt;
      end else begin
        tick_r <= tick_inc;
      end
    end
  end

endmodule

[hdl/bsbm_back.sv]
// Back end: lit counters, per-segment brightness divider and row assembly.
module bsbm_back #(
  parameter int DIGITS     = 4,
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsbm_pkg::cfg_t      cfg,
  input  logic                cmd_empty,
  input  logic [DIGITS*7:0]   cmd_data,
  output logic                cmd_pop,
  output logic                row_push,
  output bsbm_pkg::out_row_t  row_data,
  input  logic                row_full
);

  import bsbm_pkg::*;

  localparam int NSEG  = DIGITS * 8;
  localparam int IDXW  = $clog2(NSEG);
  localparam int DIGW  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CW10  = COUNT_BITS + 10;
  localparam int NUM_W = ((CW10 > 24) ? CW10 : 24) + 2;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RD   = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_SUM  = 8'b0000_1000,
    ST_CHK  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_WR   = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [DIGW-1:0]         dig_r;
  logic [2:0]              seg_r;
  logic [IDXW-1:0]         idx;
  logic [COUNT_BITS-1:0]   lit_r [NSEG];
  logic [NSEG-1:0]         vld_r;
  logic [7:0]              old;
  logic [7:0]              old_r;
  logic [23:0]             prod_r;
  logic [CW10-1:0]         cnt_r;
  logic [NUM_W-1:0]        num_r;
  logic [24:0]             rem_r;
  logic [24:0]             dsh;
  logic [7:0]              q_r;
  logic [2:0]              bit_r;
  logic                    chg_r;
  logic [7:0]              lv_r [8];
  logic [15:0]             n_val;
  logic [16:0]             d_val;
  logic                    sat;
  logic                    last;
  logic                    cmd_kind;
  logic [DIGITS-1:0][6:0]  cmd_pat;
  logic [7:0]              ram_rdata;

  assign idx      = IDXW'({dig_r, seg_r});
  assign n_val    = (cfg.steps_per_frame == 16'd0) ? 16'd1 : cfg.steps_per_frame;
  assign d_val    = {n_val, 1'b0};
  assign sat      = (num_r >= NUM_W'({d_val, 8'd0}));
  assign dsh      = 25'(d_val) << bit_r;
  assign last     = (dig_r == DIGW'(DIGITS - 1));
  assign cmd_kind = cmd_data[DIGITS*7];
  assign cmd_pat  = cmd_data[DIGITS*7-1:0];
  assign old      = vld_r[idx] ? ram_rdata : 8'd0;

  bsbm_ram #(.WIDTH(8), .DEPTH(NSEG)) u_level (
    .clk   (clk),
    .we    (state_r == ST_WR),
    .waddr (idx),
    .wdata (q_r),
    .re    (state_r == ST_RD),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && cmd_kind == CMD_FRAME) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_CHK;
      ST_CHK: state_nxt = sat ? ST_WR : ST_DIV;
      ST_DIV: begin
        if (bit_r == 3'd0) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR:  state_nxt = (seg_r == 3'd7) ? ST_EMIT : ST_RD;
      ST_EMIT: begin
        if (!row_full) begin
          state_nxt = last ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = ((state_r == ST_IDLE) && !cmd_empty && cmd_kind == CMD_SAMPLE) ||
               ((state_r == ST_EMIT) && !row_full && last);
    row_push = (state_r == ST_EMIT) && !row_full;
    row_data.digit_index  = 2'(dig_r);
    row_data.bright_a     = lv_r[0];
    row_data.bright_b     = lv_r[1];
    row_data.bright_c     = lv_r[2];
    row_data.bright_d     = lv_r[3];
    row_data.bright_e     = lv_r[4];
    row_data.bright_f     = lv_r[5];
    row_data.bright_g     = lv_r[6];
    row_data.bright_point = lv_r[7];
    row_data.row_changed  = chg_r;
    row_data.last_row     = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
      for (int i = 0; i < NSEG; i++) begin
        lit_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_IDLE) && !cmd_empty && cmd_kind == CMD_SAMPLE) begin
        // bump every counter whose segment is lit, saturating at full scale
        for (int d = 0; d < DIGITS; d++) begin
          for (int s = 0; s < 7; s++) begin
            if (cmd_pat[d][s] && lit_r[d*8+s] != CNT_MAX) begin
              lit_r[d*8+s] <= lit_r[d*8+s] + 1'b1;
            end
          end
        end
      end else if (state_r == ST_WR) begin
        lit_r[idx] <= '0;
        vld_r[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        dig_r <= '0;
        seg_r <= '0;
        chg_r <= 1'b0;
      end
      ST_MUL: begin
        old_r  <= old;
        prod_r <= old * n_val;
        cnt_r  <= lit_r[idx] * 10'd600;
      end
      ST_SUM: begin
        num_r <= NUM_W'(prod_r) + NUM_W'(cnt_r) + NUM_W'(n_val * 5'd30);
      end
      ST_CHK: begin
        if (sat) begin
          q_r <= 8'hFF;
        end else begin
          rem_r <= num_r[24:0];
          q_r   <= 8'd0;
          bit_r <= 3'd7;
        end
      end
      ST_DIV: begin
        // one restoring step per cycle, most significant quotient bit first
        if (rem_r >= dsh) begin
          rem_r        <= rem_r - dsh;
          q_r[bit_r]   <= 1'b1;
        end
        bit_r <= bit_r - 1'b1;
      end
      ST_WR: begin
        lv_r[seg_r] <= q_r;
        chg_r       <= chg_r | (q_r != old_r);
        seg_r       <= seg_r + 1'b1;
      end
      ST_EMIT: begin
        if (!row_full && !last) begin
          dig_r <= dig_r + 1'b1;
          chg_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/bsbm_checker.sv]
// Port-level checks of the brightness monitor and their bind to the top level.
`include "bcd_segment_brightness_monitor_top_macros.svh"

module bsbm_checker #(
  parameter int DIGITS = 4
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input bsbm_pkg::out_row_t out_row
);

  import bsbm_pkg::*;

  `BSBM_ASSERT_RST(a_reset_clears, !rst_n, out_empty && !in_full, "queues not empty after reset")
  `BSBM_ASSERT_NEXT(a_row_holds, !out_empty && !out_pop, !out_empty && $stable(out_row), "waiting row changed")
  `BSBM_ASSERT_IMP(a_last_row, !out_empty && (DIGITS <= 4), out_row.last_row == (out_row.digit_index == 2'(DIGITS - 1)), "last_row flag disagrees with digit index")
  `BSBM_ASSERT_IMP(a_point_dark, !out_empty, out_row.bright_point < 8'd30, "decimal point level out of range")

endmodule

bind bcd_segment_brightness_monitor_top bsbm_checker #(.DIGITS(DIGITS)) u_bsbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_row   (out_row)
);
